// ===== design/shng_pkg.sv =====
// Shared constants, codes and control/status types of the spatial hash neighbour grid.
`timescale 1ns / 1ps
package shng_pkg;

	localparam int DEF_PARTICLES      = 2048;
	localparam int DEF_BUCKETS        = 8192;
	localparam int DEF_MAX_NEIGHBOURS = 64;

	localparam logic [31:0] PRIME_X = 32'd73856093;
	localparam logic [31:0] PRIME_Y = 32'd19349663;
	localparam logic [31:0] PRIME_Z = 32'd83492791;

	localparam logic [13:0] BKT_TOTAL_RESET = 14'd4099;
	localparam logic [23:0] INV_CELL_RESET  = 24'd262144;

	// Word kinds.
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic CFG_BKT_TOTAL = 1'b0;
	localparam logic CFG_INV_CELL  = 1'b1;

	typedef struct packed {
		logic latch_item;
		logic clr_write;
		logic mul_go;
		logic cell_init;
		logic cell_next;
		logic mod_start;
		logic head_read;
		logic ins_write;
		logic walk_take;
		logic set_trunc;
		logic push_final;
	} shng_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       slot_ok;
		logic       clr_done;
		logic       mul_done;
		logic       mod_done;
		logic       cur_empty;
		logic       count_zero;
		logic       count_full;
		logic       cell_last;
		logic       out_free;
	} shng_stat_t;

endpackage

// ===== design/shng_mod.sv =====
// Iterative restoring modulo unit: 32-bit dividend, one quotient bit per cycle.
`timescale 1ns / 1ps
module shng_mod #(
	parameter int NW = 14,
	parameter int BW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [NW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [BW-1:0] rem
);

	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [31:0]   dvd_q;
	logic [NW-1:0] r_q;
	logic [NW:0]   trial;

	assign trial = {r_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, divisor})
				r_q <= NW'(trial - {1'b0, divisor});
			else
				r_q <= NW'(trial);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = BW'(r_q);

endmodule

// ===== design/shng_datapath.sv =====
// Datapath: item registers, shared multiplier, hash, modulo unit, bucket and link memories.
`timescale 1ns / 1ps
module shng_datapath #(
	parameter int PARTICLES      = 2048,
	parameter int BUCKETS        = 8192,
	parameter int MAX_NEIGHBOURS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  shng_pkg::shng_cmd_t cmd,
	output shng_pkg::shng_stat_t stat,
	input  logic [13:0]         bkt_total,
	input  logic [23:0]         inverse_cell_size,
	input  logic [1:0]          kind,
	input  logic [10:0]         particle_index,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [10:0]         neighbour_index,
	output logic                neighbour_valid,
	output logic                last,
	output logic                truncated
);
	import shng_pkg::*;

	localparam int PW = $clog2(PARTICLES);
	localparam int BW = $clog2(BUCKETS);
	localparam int NW = ($clog2(BUCKETS + 1) > 14) ? $clog2(BUCKETS + 1) : 14;
	localparam int CW = $clog2(MAX_NEIGHBOURS + 1);

	// Item registers.
	logic [1:0]         kind_q;
	logic [10:0]        slot_q;
	logic signed [31:0] px_q, py_q, pz_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			kind_q <= kind;
			slot_q <= particle_index;
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
		end
	end

	logic          slot_ok;
	logic [PW-1:0] slot_w;
	assign slot_ok = 32'(slot_q) < 32'(PARTICLES);
	assign slot_w  = PW'(32'(slot_q));

	// Shared multiplier: cell products first, then prime products.
	logic [2:0]         step_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [23:0]        cx_q, cy_q, cz_q;
	logic [31:0]        bx_q, by_q, bz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (cmd.mul_go)
			step_q <= (step_q == 3'd5) ? 3'd0 : step_q + 3'd1;
	end

	always_comb begin
		case (step_q)
			3'd0:    mul_a = {px_q[31], px_q};
			3'd1:    mul_a = {py_q[31], py_q};
			3'd2:    mul_a = {pz_q[31], pz_q};
			3'd3:    mul_a = {{9{cx_q[23]}}, cx_q};
			3'd4:    mul_a = {{9{cy_q[23]}}, cy_q};
			3'd5:    mul_a = {{9{cz_q[23]}}, cz_q};
			default: mul_a = '0;
		endcase
		case (step_q)
			3'd3:    mul_b = $signed({1'b0, PRIME_X});
			3'd4:    mul_b = $signed({1'b0, PRIME_Y});
			3'd5:    mul_b = $signed({1'b0, PRIME_Z});
			default: mul_b = $signed({9'd0, inverse_cell_size});
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			case (step_q)
				3'd0:    cx_q <= mul_p[55:32];
				3'd1:    cy_q <= mul_p[55:32];
				3'd2:    cz_q <= mul_p[55:32];
				3'd3:    bx_q <= mul_p[31:0];
				3'd4:    by_q <= mul_p[31:0];
				3'd5:    bz_q <= mul_p[31:0];
				default: cx_q <= cx_q;
			endcase
		end
	end

	// Neighbour offsets: code 0 is -1, 1 is 0, 2 is +1.
	logic [1:0] ox_q, oy_q, oz_q;

	always_ff @(posedge clk) begin
		if (cmd.cell_init) begin
			if (kind_q == KIND_QUERY) begin
				ox_q <= 2'd0;
				oy_q <= 2'd0;
				oz_q <= 2'd0;
			end else begin
				ox_q <= 2'd1;
				oy_q <= 2'd1;
				oz_q <= 2'd1;
			end
		end else if (cmd.cell_next) begin
			if (ox_q != 2'd2) begin
				ox_q <= ox_q + 2'd1;
			end else begin
				ox_q <= 2'd0;
				if (oy_q != 2'd2) begin
					oy_q <= oy_q + 2'd1;
				end else begin
					oy_q <= 2'd0;
					oz_q <= oz_q + 2'd1;
				end
			end
		end
	end

	function automatic logic [31:0] hterm(input logic [31:0] base, input logic [1:0] off,
			input logic [31:0] prime);
		case (off)
			2'd0:    hterm = base - prime;
			2'd2:    hterm = base + prime;
			default: hterm = base;
		endcase
	endfunction

	logic [31:0]   hash;
	logic [NW-1:0] bc_ext, divisor;
	logic [BW-1:0] bucket;
	logic          mod_busy, mod_done;

	assign hash = hterm(bx_q, ox_q, PRIME_X) ^ hterm(by_q, oy_q, PRIME_Y)
		^ hterm(bz_q, oz_q, PRIME_Z);

	always_comb begin
		bc_ext = NW'(bkt_total);
		if (bc_ext == '0)
			divisor = NW'(1);
		else if (bc_ext > NW'(BUCKETS))
			divisor = NW'(BUCKETS);
		else
			divisor = bc_ext;
	end

	shng_mod #(.NW(NW), .BW(BW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (hash),
		.divisor  (divisor),
		.busy     (mod_busy),
		.done     (mod_done),
		.rem      (bucket)
	);

	// Clearing sweep over the bucket heads.
	logic [BW-1:0] clr_q;
	logic          clr_done;
	assign clr_done = clr_q == BW'(BUCKETS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_write)
			clr_q <= clr_done ? '0 : clr_q + BW'(1);
	end

	// Memories; an entry is {empty, slot}.
	logic [PW:0] head_mem [BUCKETS];
	logic [PW:0] link_mem [PARTICLES];
	logic [PW:0] head_rd_q, link_rd_q, cur;
	logic        sel_link_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_write)
			head_mem[clr_q] <= {1'b1, {PW{1'b0}}};
		else if (cmd.ins_write)
			head_mem[bucket] <= {1'b0, slot_w};
		if (cmd.head_read)
			head_rd_q <= head_mem[bucket];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write)
			link_mem[slot_w] <= head_rd_q;
		if (cmd.walk_take)
			link_rd_q <= link_mem[cur[PW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_link_q <= 1'b0;
		else if (cmd.head_read)
			sel_link_q <= 1'b0;
		else if (cmd.walk_take)
			sel_link_q <= 1'b1;
	end

	assign cur = sel_link_q ? link_rd_q : head_rd_q;

	// Found-slot count, one slot held back so the final word can be marked.
	logic [CW-1:0] count_q;
	logic [PW-1:0] pend_q;
	logic          trunc_q;
	logic          count_zero, count_full, push_mid, out_free;

	assign count_zero = count_q == '0;
	assign count_full = count_q == CW'(MAX_NEIGHBOURS);
	assign push_mid   = cmd.walk_take && !count_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			trunc_q <= 1'b0;
		end else if (cmd.latch_item) begin
			count_q <= '0;
			trunc_q <= 1'b0;
		end else begin
			if (cmd.walk_take)
				count_q <= count_q + CW'(1);
			if (cmd.set_trunc)
				trunc_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_take)
			pend_q <= cur[PW-1:0];
	end

	// Output register.
	logic        out_valid_q;
	logic [10:0] o_idx_q;
	logic        o_nv_q, o_last_q, o_trunc_q;
	logic        final_hit;

	assign out_free  = !out_valid_q || !out_stall;
	assign final_hit = (kind_q == KIND_QUERY) && !count_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push_mid || cmd.push_final)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push_mid) begin
			o_idx_q   <= 11'(pend_q);
			o_nv_q    <= 1'b1;
			o_last_q  <= 1'b0;
			o_trunc_q <= 1'b0;
		end else if (cmd.push_final) begin
			o_idx_q   <= final_hit ? 11'(pend_q) : 11'd0;
			o_nv_q    <= final_hit;
			o_last_q  <= 1'b1;
			o_trunc_q <= final_hit && trunc_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign neighbour_index = o_idx_q;
	assign neighbour_valid = o_nv_q;
	assign last            = o_last_q;
	assign truncated       = o_trunc_q;

	assign stat.kind       = kind_q;
	assign stat.slot_ok    = slot_ok;
	assign stat.clr_done   = clr_done;
	assign stat.mul_done   = step_q == 3'd5;
	assign stat.mod_done   = mod_done;
	assign stat.cur_empty  = cur[PW];
	assign stat.count_zero = count_zero;
	assign stat.count_full = count_full;
	assign stat.cell_last  = (ox_q == 2'd2) && (oy_q == 2'd2) && (oz_q == 2'd2);
	assign stat.out_free   = out_free;

`ifndef ASSERT_OFF
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_mid || cmd.push_final) |-> out_free)
		else $error("result pushed while output register is held");
	a_mod_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |-> !mod_busy)
		else $error("modulo started while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_take |-> !count_full)
		else $error("slot taken beyond the neighbour limit");
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_write && cmd.ins_write))
		else $error("clear and insert write the head memory together");
`endif

endmodule

// ===== design/shng_ctrl.sv =====
// Controller state machine sequencing clear, insert and query words.
`timescale 1ns / 1ps
module shng_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  shng_pkg::shng_stat_t stat,
	output shng_pkg::shng_cmd_t  cmd
);
	import shng_pkg::*;

	typedef enum logic [10:0] {
		S_INIT   = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_DECODE = 11'b00000000100,
		S_CLR    = 11'b00000001000,
		S_MUL    = 11'b00000010000,
		S_HASH   = 11'b00000100000,
		S_MOD    = 11'b00001000000,
		S_HEAD   = 11'b00010000000,
		S_INS    = 11'b00100000000,
		S_WALK   = 11'b01000000000,
		S_FIN    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT;
		else
			state_q <= state_d;
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.clr_write = 1'b1;
				if (stat.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.kind == KIND_CLEAR)
					state_d = S_CLR;
				else if ((stat.kind == KIND_INSERT && stat.slot_ok) || stat.kind == KIND_QUERY)
					state_d = S_MUL;
				else
					state_d = S_FIN;
			end
			S_CLR: begin
				cmd.clr_write = 1'b1;
				if (stat.clr_done)
					state_d = S_FIN;
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				if (stat.mul_done) begin
					cmd.cell_init = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.mod_start = 1'b1;
				state_d = S_MOD;
			end
			S_MOD: begin
				if (stat.mod_done)
					state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.head_read = 1'b1;
				state_d = (stat.kind == KIND_INSERT) ? S_INS : S_WALK;
			end
			S_INS: begin
				cmd.ins_write = 1'b1;
				state_d = S_FIN;
			end
			S_WALK: begin
				if (stat.cur_empty) begin
					if (stat.cell_last) begin
						state_d = S_FIN;
					end else begin
						cmd.cell_next = 1'b1;
						state_d = S_HASH;
					end
				end else if (stat.count_full) begin
					cmd.set_trunc = 1'b1;
					state_d = S_FIN;
				end else if (stat.count_zero || stat.out_free) begin
					cmd.walk_take = 1'b1;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.push_final = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

endmodule

// ===== design/spatial_hash_neighbour_grid_core.sv =====
// Top level of the spatial hash neighbour grid: configuration port, controller and datapath.
`timescale 1ns / 1ps
// The grid keeps one chain per hash bucket. A clear word empties every bucket head
// by sweeping the head memory, one entry a cycle; the same sweep runs after reset,
// and no word is accepted until it finishes (configuration writes are taken
// throughout). An insert word, once accepted, passes through a decode step, the
// cell and prime products on the shared multiplier, a start step and the bit-serial
// modulo unit, then a head read, the head and link writes and the result push. A
// query word makes, for each of the 27 neighbour cells, one pass through the modulo
// unit plus a head read and a walk; chains are walked one slot a cycle while the
// output side takes words.
// Every word ends in exactly one result word marked last; clear, insert and queries
// that find nothing give a single empty word. The output register lets the next input
// word be accepted while the final result still waits to be taken.
module spatial_hash_neighbour_grid_core #(
	parameter int PARTICLES      = shng_pkg::DEF_PARTICLES,
	parameter int BUCKETS        = shng_pkg::DEF_BUCKETS,
	parameter int MAX_NEIGHBOURS = shng_pkg::DEF_MAX_NEIGHBOURS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [10:0]        particle_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [10:0]        neighbour_index,
	output logic               neighbour_valid,
	output logic               last,
	output logic               truncated
);
	import shng_pkg::*;

	// Configuration registers; a write lands in the access cycle.
	logic [13:0] bkt_total_q;
	logic [23:0] inv_cell_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_total_q <= BKT_TOTAL_RESET;
			inv_cell_q  <= INV_CELL_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				CFG_BKT_TOTAL: bkt_total_q <= pwdata[13:0];
				CFG_INV_CELL:  inv_cell_q  <= pwdata[23:0];
				default:       bkt_total_q <= bkt_total_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_BKT_TOTAL: prdata = {18'd0, bkt_total_q};
			CFG_INV_CELL:  prdata = {8'd0, inv_cell_q};
			default:       prdata = '0;
		endcase
	end

	// The controller only takes a word while it stands idle.
	shng_cmd_t  cmd;
	shng_stat_t stat;
	logic       in_ready;

	assign in_stall = !in_ready;

	shng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	shng_datapath #(
		.PARTICLES      (PARTICLES),
		.BUCKETS        (BUCKETS),
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.bkt_total         (bkt_total_q),
		.inverse_cell_size (inv_cell_q),
		.kind              (kind),
		.particle_index    (particle_index),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.pos_z             (pos_z),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.neighbour_index   (neighbour_index),
		.neighbour_valid   (neighbour_valid),
		.last              (last),
		.truncated         (truncated)
	);

endmodule
